FILE: rtl/gsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, constants and helpers of the glyph shelf packer.
// ----------------------------------------------------------------------------
package gsp_pkg;

  // Hard cap on atlas height, applied on top of the max_texture_size register
  localparam int MAX_TEXTURE_DIM = 16384;
  localparam int GAP             = 1;

  // Register and field widths
  localparam int AW_W       = 11;
  localparam int MAXT_W     = 15;
  localparam int FONT_W     = 11;
  localparam int RAD_W      = 7;
  localparam int CFG_DATA_W = 15;
  localparam int GLYPH_W    = 11;
  localparam int POS_W      = 15;
  localparam int STATUS_W   = 2;

  // Internal widths
  localparam int PAD_W    = 12;          // glyph plus padding on both sides
  localparam int PEN_X_W  = 15;
  localparam int PEN_Y_W  = 16;
  localparam int ROW_W    = 12;
  localparam int HEIGHT_W = 16;
  localparam int SUM_W    = 17;          // pen + padded size + gap
  localparam int GROW_W   = SUM_W + 1;   // power of two above a SUM_W value
  localparam int DIM_W    = $clog2(MAX_TEXTURE_DIM + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ATLAS_WIDTH      = 2'd0,
    CFG_MAX_TEXTURE_SIZE = 2'd1,
    CFG_FONT_SIZE        = 2'd2,
    CFG_OUTLINE_RADIUS   = 2'd3
  } cfg_index_t;

  // Function codes of an input transaction
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAILED  = 2'd2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PLACE = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef struct packed {
    logic [AW_W-1:0]   atlas_width;
    logic [MAXT_W-1:0] max_texture_size;
    logic [FONT_W-1:0] font_size;
    logic [RAD_W-1:0]  outline_radius;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [PAD_W-1:0] w;
    logic [PAD_W-1:0] h;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } queue_stat_t;

  typedef struct packed {
    logic pop;
    logic failed;
  } back_stat_t;

  // Smallest power of two strictly greater than v: smear the top bit down, add one
  function automatic logic [GROW_W-1:0] pow2_above(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] m;
    m = v;
    for (int s = 1; s < SUM_W; s = s * 2) begin
      m = m | (m >> s);
    end
    return {1'b0, m} + GROW_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_in_if / gsp_out_if
// Valid/ready channels carrying glyph commands in and placements out.
// ----------------------------------------------------------------------------
interface gsp_in_if;
  import gsp_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [GLYPH_W-1:0] glyph_width;
  logic [GLYPH_W-1:0] glyph_height;

  modport source(output valid, func, glyph_width, glyph_height, input ready);
  modport sink(input valid, func, glyph_width, glyph_height, output ready);
endinterface

interface gsp_out_if;
  import gsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [POS_W-1:0]    atlas_height;
  logic [STATUS_W-1:0] status;

  modport source(output valid, pos_x, pos_y, atlas_height, status, input ready);
  modport sink(input valid, pos_x, pos_y, atlas_height, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/gsp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_front
// Accepts glyph transactions, classifies them and pads the glyph size.
// ----------------------------------------------------------------------------
module gsp_front (
  gsp_in_if.sink          glyph_in,
  input  gsp_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output gsp_pkg::cmd_t   cmd
);
  import gsp_pkg::*;

  // Take a transaction whenever the queue has a free slot
  assign glyph_in.ready = !q_full;
  assign push           = glyph_in.valid && !q_full;

  // Classify: begin, empty glyph (no bitmap) or real placement
  always_comb begin
    if (glyph_in.func == FUNC_BEGIN) begin
      cmd.op = OP_BEGIN;
    end else if (glyph_in.glyph_width == '0 || glyph_in.glyph_height == '0) begin
      cmd.op = OP_EMPTY;
    end else begin
      cmd.op = OP_PLACE;
    end
    // Outline padding on both sides
    cmd.w = PAD_W'(glyph_in.glyph_width) + PAD_W'({cfg.outline_radius, 1'b0});
    cmd.h = PAD_W'(glyph_in.glyph_height) + PAD_W'({cfg.outline_radius, 1'b0});
  end

endmodule
`default_nettype wire

FILE: rtl/gsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_queue
// Short command FIFO decoupling the front from the placement back end.
// ----------------------------------------------------------------------------
module gsp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gsp_pkg::cmd_t        push_data,
  input  logic                 pop,
  output gsp_pkg::cmd_t        pop_data,
  output gsp_pkg::queue_stat_t stat
);
  import gsp_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data   = entries[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule
`default_nettype wire

FILE: rtl/gsp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_back
// Shelf placement: pen, row height and atlas height state plus the result
// register.
// ----------------------------------------------------------------------------
module gsp_back (
  input  logic                clk,
  input  logic                rst,
  input  gsp_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  gsp_pkg::cmd_t       cmd,
  gsp_out_if.source           result_out,
  output gsp_pkg::back_stat_t stat
);
  import gsp_pkg::*;

  // Placement state
  logic [PEN_X_W-1:0]  pen_x,      pen_x_next;
  logic [PEN_Y_W-1:0]  pen_y,      pen_y_next;
  logic [ROW_W-1:0]    row_height, row_height_next;
  logic [HEIGHT_W-1:0] cur_height, cur_height_next;
  logic                failed,     failed_next;

  // Result register
  logic                out_valid;
  logic [POS_W-1:0]    pos_x,  pos_x_next;
  logic [POS_W-1:0]    pos_y,  pos_y_next;
  logic [STATUS_W-1:0] status, status_next;

  logic                pop;
  logic [SUM_W-1:0]    sum_x;
  logic                wrap;
  logic [SUM_W-1:0]    y_wrap_sum;
  logic [PEN_Y_W-1:0]  y_eff;
  logic [ROW_W-1:0]    row_eff;
  logic [SUM_W-1:0]    sum_y;
  logic                need_grow;
  logic [GROW_W-1:0]   grown;
  logic [GROW_W-1:0]   limit;
  logic                too_big;
  logic [HEIGHT_W-1:0] begin_height;
  logic [PEN_X_W-1:0]  x_after_wrap;

  // Pop whenever the result slot is free or being drained
  assign pop = q_valid && (!out_valid || result_out.ready);

  // Row wrap check and the wrapped pen position
  assign sum_x      = SUM_W'(pen_x) + SUM_W'(cmd.w) + SUM_W'(GAP);
  assign wrap       = SUM_W'(cfg.atlas_width) < sum_x;
  assign y_wrap_sum = SUM_W'(pen_y) + SUM_W'(row_height) + SUM_W'(GAP);
  assign y_eff      = wrap ? y_wrap_sum[PEN_Y_W-1:0] : pen_y;
  assign row_eff    = wrap ? '0 : row_height;

  // Height check and power-of-two growth against the smaller limit
  assign sum_y     = SUM_W'(y_eff) + SUM_W'(cmd.h) + SUM_W'(GAP);
  assign need_grow = SUM_W'(cur_height) < sum_y;
  assign grown     = pow2_above(sum_y);
  assign limit     = (GROW_W'(cfg.max_texture_size) < GROW_W'(MAX_TEXTURE_DIM))
                   ? GROW_W'(cfg.max_texture_size) : GROW_W'(MAX_TEXTURE_DIM);
  assign too_big   = need_grow && (grown > limit);

  // Initial atlas height of a new atlas
  logic [GROW_W-1:0] begin_pow;
  assign begin_pow    = pow2_above(SUM_W'(cfg.font_size));
  assign begin_height = begin_pow[HEIGHT_W-1:0];

  // Pen after a glyph placed at x = 1 on a fresh row
  assign x_after_wrap = PEN_X_W'(cmd.w) + PEN_X_W'(1 + GAP);

  // Next state and next result
  always_comb begin
    pen_x_next      = pen_x;
    pen_y_next      = pen_y;
    row_height_next = row_height;
    cur_height_next = cur_height;
    failed_next     = failed;
    pos_x_next      = '0;
    pos_y_next      = '0;
    status_next     = STATUS_OK;
    case (cmd.op)
      OP_BEGIN: begin
        pen_x_next      = PEN_X_W'(1);
        pen_y_next      = PEN_Y_W'(1);
        row_height_next = '0;
        cur_height_next = begin_height;
        failed_next     = 1'b0;
      end
      OP_EMPTY: begin
        if (failed) begin
          status_next = STATUS_FAILED;
        end
      end
      OP_PLACE: begin
        if (failed) begin
          status_next = STATUS_FAILED;
        end else begin
          // Wrap stays in effect even when the height check fails
          pen_y_next      = y_eff;
          row_height_next = row_eff;
          if (wrap) begin
            pen_x_next = PEN_X_W'(1);
          end
          if (too_big) begin
            failed_next = 1'b1;
            status_next = STATUS_NO_ROOM;
          end else begin
            if (need_grow) begin
              cur_height_next = grown[HEIGHT_W-1:0];
            end
            if (ROW_W'(cmd.h) > row_eff) begin
              row_height_next = ROW_W'(cmd.h);
            end
            pen_x_next = wrap ? x_after_wrap : sum_x[PEN_X_W-1:0];
            pos_x_next = wrap ? POS_W'(1) : POS_W'(pen_x);
            pos_y_next = y_eff[POS_W-1:0];
          end
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x      <= PEN_X_W'(1);
      pen_y      <= PEN_Y_W'(1);
      row_height <= '0;
      cur_height <= '0;
      failed     <= 1'b0;
    end else if (pop) begin
      pen_x      <= pen_x_next;
      pen_y      <= pen_y_next;
      row_height <= row_height_next;
      cur_height <= cur_height_next;
      failed     <= failed_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  logic [POS_W-1:0] atlas_height;
  always_ff @(posedge clk) begin
    if (pop) begin
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      status       <= status_next;
      atlas_height <= cur_height_next[POS_W-1:0];
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.pos_x        = pos_x;
  assign result_out.pos_y        = pos_y;
  assign result_out.atlas_height = atlas_height;
  assign result_out.status       = status;

  assign stat.pop    = pop;
  assign stat.failed = failed;

endmodule
`default_nettype wire

FILE: rtl/glyph_shelf_packer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_shelf_packer_unit
// Shelf packer that assigns atlas positions to padded glyph rectangles.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the command queue has a free slot and
// returns one result per transaction, in order. A begin (func 0) opens a new
// atlas; a place (func 1) returns the top-left corner of the padded glyph, the
// atlas height and a status. An accepted transaction is written into a
// two-entry command queue and then goes through the placement stage, whose
// update of pen, row height and atlas height (wrap check, height check,
// power-of-two growth) sets the rate of one transaction per cycle while
// results are taken. The result sits in an output register; while it waits
// to be taken, the queue still accepts up to two more transactions.
// Configuration writes belong in idle periods.
// ----------------------------------------------------------------------------
module glyph_shelf_packer_unit (
  input  logic                           clk,
  input  logic                           rst,
  gsp_in_if.sink                         glyph_in,
  gsp_out_if.source                      result_out,
  input  logic                           cfg_we,
  input  gsp_pkg::cfg_index_t            cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsp_pkg::*;

  cfg_t        cfg;
  logic        push;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;
  queue_stat_t q_stat;
  back_stat_t  back_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.atlas_width      <= AW_W'(128);
      cfg.max_texture_size <= MAXT_W'(2048);
      cfg.font_size        <= FONT_W'(16);
      cfg.outline_radius   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:      cfg.atlas_width      <= cfg_data[AW_W-1:0];
        CFG_MAX_TEXTURE_SIZE: cfg.max_texture_size <= cfg_data[MAXT_W-1:0];
        CFG_FONT_SIZE:        cfg.font_size        <= cfg_data[FONT_W-1:0];
        CFG_OUTLINE_RADIUS:   cfg.outline_radius   <= cfg_data[RAD_W-1:0];
        default:              cfg                  <= cfg;
      endcase
    end
  end

  gsp_front u_front (
    .glyph_in (glyph_in),
    .cfg      (cfg),
    .q_full   (q_stat.full),
    .push     (push),
    .cmd      (push_cmd)
  );

  gsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (back_stat.pop),
    .pop_data  (pop_cmd),
    .stat      (q_stat)
  );

  gsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (!q_stat.empty),
    .cmd        (pop_cmd),
    .result_out (result_out),
    .stat       (back_stat)
  );

  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= CNT_W'(QUEUE_DEPTH))
    else $error("command queue over depth");

  // Back end only pops real commands
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    back_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A failure status on the output means the failure flag is set
  a_fail_flag: assert property (@(posedge clk) disable iff (rst)
    result_out.valid &&
    (result_out.status == STATUS_NO_ROOM || result_out.status == STATUS_FAILED)
    |-> back_stat.failed)
    else $error("failure status without failure flag");

  // Accepted transaction enters the queue on the next cycle
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    glyph_in.valid && glyph_in.ready && !back_stat.pop
    |=> q_stat.count == $past(q_stat.count) + CNT_W'(1))
    else $error("queue count did not track push");

endmodule
`default_nettype wire
